// File: rtl/core/bba_pkg.sv
// Buddy allocator package: node status codes, response codes, and the
// command/status structs that join the controller and the datapath.
// Depends on nothing.
package bba_pkg;

  localparam logic [1:0] NS_UNUSED = 2'd0;
  localparam logic [1:0] NS_FREE   = 2'd1;
  localparam logic [1:0] NS_ALLOC  = 2'd2;
  localparam logic [1:0] NS_SPLIT  = 2'd3;

  localparam logic [1:0] RSP_OK      = 2'd0;
  localparam logic [1:0] RSP_NOFIT   = 2'd1;
  localparam logic [1:0] RSP_BADADDR = 2'd2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam int ADDR_W = 12;

  typedef enum logic [2:0] {
    STEP_HOLD, STEP_SKIP, STEP_LEFT, STEP_DESCEND, STEP_PARENT
  } step_e;

  typedef enum logic [2:0] {
    WS_NODE, WS_RIGHT, WS_BUDDY, WS_PARENT, WS_CLEAR
  } wsel_e;

  typedef enum logic [1:0] {
    RS_ZERO, RS_START, RS_ADDR
  } rsrc_e;

  typedef struct packed {
    logic       load;
    logic       rd_buddy;
    logic       wr_en;
    wsel_e      wr_sel;
    logic [1:0] wr_val;
    step_e      step;
    logic       rsp_valid;
    logic [1:0] rsp_status;
    rsrc_e      rsp_src;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] node_st;
    logic       lt_want;
    logic       skip_last;
    logic       at_root;
    logic       addr_match;
    logic       clr_done;
    logic       order_bad;
  } dp_stat_t;

  // Largest L with 2^L <= leaf count, capped at 16 (elaboration only).
  function automatic int tree_levels(int leaf);
    int lv;
    lv = 0;
    for (int i = 0; i < 16; i++) begin
      if ((2 << lv) <= leaf) begin
        lv = lv + 1;
      end
    end
    return lv;
  endfunction

endpackage

// File: rtl/core/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module bba_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/core/bba_datapath.sv
// Buddy allocator datapath: node pointer, request registers, node status
// RAM, clear counter and response registers. Depends on bba_pkg, bba_ram.
module bba_datapath #(
  parameter int LV        = 8,
  parameter int MIN_BYTES = 16,
  parameter int CW        = 12
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bba_pkg::dp_cmd_t          cmd_i,
  output bba_pkg::dp_stat_t         stat_o,
  input  logic [3:0]                size_order_i,
  input  logic [bba_pkg::ADDR_W-1:0] block_address_i,
  output logic                      done_o,
  output logic [1:0]                status_o,
  output logic [bba_pkg::ADDR_W-1:0] granted_address_o
);

  localparam int NW = LV + 1;
  localparam int DW = (LV > 0) ? $clog2(LV + 1) : 1;

  logic [NW-1:0] v_q, v_d, clr_q;
  logic [DW-1:0] want_q;
  logic [bba_pkg::ADDR_W-1:0] addr_q;
  logic [NW-1:0] right_v, buddy_v, parent_v, skip_v, waddr, raddr;
  logic [1:0] wdata, rdata;
  logic [CW-1:0] cur_start, right_start, addr_ext;
  logic skip_last;
  logic [4:0] want_full;

  function automatic logic [DW-1:0] depth_of(logic [NW-1:0] v);
    logic [DW-1:0] d;
    d = '0;
    for (int i = 0; i < NW; i++) begin
      if (v[i]) begin
        d = DW'(i);
      end
    end
    return d;
  endfunction

  function automatic logic [CW-1:0] start_of(logic [NW-1:0] v);
    logic [DW-1:0] d;
    logic [NW-1:0] pos;
    logic [31:0] prod;
    d = depth_of(v);
    pos = (v << (LV - int'(d))) - (NW'(1) << LV);
    prod = 32'(pos) * 32'(MIN_BYTES);
    return prod[CW-1:0];
  endfunction

  assign right_v   = (v_q << 1) | NW'(1);
  assign buddy_v   = v_q ^ NW'(1);
  assign parent_v  = v_q >> 1;
  assign cur_start = start_of(v_q);
  assign right_start = start_of(right_v);
  assign addr_ext  = CW'(addr_q);

  // Pre-order successor that skips the subtree below the current node.
  always_comb begin
    logic run;
    logic [4:0] t;
    logic [NW-1:0] up;
    run = 1'b1;
    t = '0;
    for (int i = 0; i < NW; i++) begin
      if (run && v_q[i]) begin
        t = t + 5'd1;
      end else begin
        run = 1'b0;
      end
    end
    up = v_q >> t;
    skip_last = (up == '0);
    skip_v = up | NW'(1);
  end

  always_comb begin
    v_d = v_q;
    if (cmd_i.load) begin
      v_d = NW'(1);
    end else begin
      case (cmd_i.step)
        bba_pkg::STEP_SKIP:    v_d = skip_v;
        bba_pkg::STEP_LEFT:    v_d = v_q << 1;
        bba_pkg::STEP_DESCEND: v_d = (addr_ext >= right_start) ? right_v : (v_q << 1);
        bba_pkg::STEP_PARENT:  v_d = parent_v;
        default:               v_d = v_q;
      endcase
    end
  end

  assign want_full = 5'(LV) - {1'b0, size_order_i};

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    if (cmd_i.load) begin
      want_q <= want_full[DW-1:0];
      addr_q <= block_address_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= NW'(1);
      done_o <= 1'b0;
    end else begin
      if (cmd_i.wr_en && cmd_i.wr_sel == bba_pkg::WS_CLEAR && !(&clr_q)) begin
        clr_q <= clr_q + NW'(1);
      end
      done_o <= cmd_i.rsp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rsp_valid) begin
      status_o <= cmd_i.rsp_status;
      case (cmd_i.rsp_src)
        bba_pkg::RS_START: granted_address_o <= cur_start[bba_pkg::ADDR_W-1:0];
        bba_pkg::RS_ADDR:  granted_address_o <= addr_q;
        default:           granted_address_o <= '0;
      endcase
    end
  end

  always_comb begin
    wdata = cmd_i.wr_val;
    case (cmd_i.wr_sel)
      bba_pkg::WS_RIGHT:  waddr = right_v;
      bba_pkg::WS_BUDDY:  waddr = buddy_v;
      bba_pkg::WS_PARENT: waddr = parent_v;
      bba_pkg::WS_CLEAR: begin
        waddr = clr_q;
        wdata = (clr_q == NW'(1)) ? bba_pkg::NS_FREE : bba_pkg::NS_UNUSED;
      end
      default:            waddr = v_q;
    endcase
  end

  assign raddr = cmd_i.rd_buddy ? buddy_v : v_q;

  bba_ram #(
    .WIDTH(2),
    .DEPTH(1 << NW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign stat_o.node_st    = rdata;
  assign stat_o.lt_want    = depth_of(v_q) < want_q;
  assign stat_o.skip_last  = skip_last;
  assign stat_o.at_root    = (v_q == NW'(1));
  assign stat_o.addr_match = (cur_start == addr_ext);
  assign stat_o.clr_done   = &clr_q;
  assign stat_o.order_bad  = {1'b0, size_order_i} > 5'(LV);

endmodule

// File: rtl/core/bba_ctrl.sv
// Buddy allocator controller: sequences the clear pass, the search/split of
// an allocation and the lookup/merge of a free. Depends on bba_pkg.
module bba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              cmd_i,
  input  bba_pkg::dp_stat_t stat_i,
  output bba_pkg::dp_cmd_t  cmd_o,
  output logic              busy
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ARD   = 4'd2;
  localparam logic [3:0] S_ACHK  = 4'd3;
  localparam logic [3:0] S_ASPL  = 4'd4;
  localparam logic [3:0] S_ASPL2 = 4'd5;
  localparam logic [3:0] S_FRD   = 4'd6;
  localparam logic [3:0] S_FCHK  = 4'd7;
  localparam logic [3:0] S_FBRD  = 4'd8;
  localparam logic [3:0] S_FBCHK = 4'd9;
  localparam logic [3:0] S_FM2   = 4'd10;
  localparam logic [3:0] S_FM3   = 4'd11;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '{load: 1'b0, rd_buddy: 1'b0, wr_en: 1'b0, wr_sel: bba_pkg::WS_NODE,
              wr_val: bba_pkg::NS_UNUSED, step: bba_pkg::STEP_HOLD, rsp_valid: 1'b0,
              rsp_status: bba_pkg::RSP_OK, rsp_src: bba_pkg::RS_ZERO};
    case (state_q)
      S_CLEAR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = bba_pkg::WS_CLEAR;
        if (stat_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          if (cmd_i == bba_pkg::CMD_FREE) begin
            state_d = S_FRD;
          end else if (stat_i.order_bad) begin
            cmd_o.rsp_valid  = 1'b1;
            cmd_o.rsp_status = bba_pkg::RSP_NOFIT;
          end else begin
            state_d = S_ARD;
          end
        end
      end
      S_ARD: state_d = S_ACHK;
      S_ACHK: begin
        if (stat_i.node_st == bba_pkg::NS_FREE) begin
          state_d = S_ASPL;
        end else if (stat_i.node_st == bba_pkg::NS_SPLIT && stat_i.lt_want) begin
          cmd_o.step = bba_pkg::STEP_LEFT;
          state_d = S_ARD;
        end else if (stat_i.skip_last) begin
          cmd_o.rsp_valid  = 1'b1;
          cmd_o.rsp_status = bba_pkg::RSP_NOFIT;
          state_d = S_IDLE;
        end else begin
          cmd_o.step = bba_pkg::STEP_SKIP;
          state_d = S_ARD;
        end
      end
      S_ASPL: begin
        cmd_o.wr_en = 1'b1;
        if (stat_i.lt_want) begin
          cmd_o.wr_val = bba_pkg::NS_SPLIT;
          state_d = S_ASPL2;
        end else begin
          cmd_o.wr_val    = bba_pkg::NS_ALLOC;
          cmd_o.rsp_valid = 1'b1;
          cmd_o.rsp_src   = bba_pkg::RS_START;
          state_d = S_IDLE;
        end
      end
      S_ASPL2: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = bba_pkg::WS_RIGHT;
        cmd_o.wr_val = bba_pkg::NS_FREE;
        cmd_o.step   = bba_pkg::STEP_LEFT;
        state_d = S_ASPL;
      end
      S_FRD: state_d = S_FCHK;
      S_FCHK: begin
        if (stat_i.node_st == bba_pkg::NS_SPLIT) begin
          cmd_o.step = bba_pkg::STEP_DESCEND;
          state_d = S_FRD;
        end else if (stat_i.node_st == bba_pkg::NS_ALLOC && stat_i.addr_match) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_val = bba_pkg::NS_FREE;
          state_d = S_FBRD;
        end else begin
          cmd_o.rsp_valid  = 1'b1;
          cmd_o.rsp_status = bba_pkg::RSP_BADADDR;
          state_d = S_IDLE;
        end
      end
      S_FBRD: begin
        if (stat_i.at_root) begin
          cmd_o.rsp_valid = 1'b1;
          cmd_o.rsp_src   = bba_pkg::RS_ADDR;
          state_d = S_IDLE;
        end else begin
          cmd_o.rd_buddy = 1'b1;
          state_d = S_FBCHK;
        end
      end
      S_FBCHK: begin
        if (stat_i.node_st == bba_pkg::NS_FREE) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_val = bba_pkg::NS_UNUSED;
          state_d = S_FM2;
        end else begin
          cmd_o.rsp_valid = 1'b1;
          cmd_o.rsp_src   = bba_pkg::RS_ADDR;
          state_d = S_IDLE;
        end
      end
      S_FM2: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = bba_pkg::WS_BUDDY;
        cmd_o.wr_val = bba_pkg::NS_UNUSED;
        state_d = S_FM3;
      end
      S_FM3: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = bba_pkg::WS_PARENT;
        cmd_o.wr_val = bba_pkg::NS_FREE;
        cmd_o.step   = bba_pkg::STEP_PARENT;
        state_d = S_FBRD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

// File: rtl/core/buddy_block_allocator_core.sv
// Top level of the binary buddy allocator: controller plus datapath.
// Depends on bba_pkg, bba_ctrl, bba_datapath (and bba_ram below it).
//
// Binary buddy allocator over a region of TOTAL_BYTES bytes cut down to blocks
// of MIN_BLOCK_BYTES. Issue a transaction by raising start while busy is low.
// An allocate (cmd_i = 0) grants the lowest-address free block of
// MIN_BLOCK_BYTES << size_order_i bytes, splitting larger blocks by halves; a
// free (cmd_i = 1) releases the allocated block that starts at block_address_i
// and merges it with free buddies. Exactly one result per transaction comes
// back on status_o / granted_address_o, marked by done_o for a single cycle;
// the receiver cannot stall it, so sample it when done_o is high. status_o is
// 0 on success, 1 when no block fits, 2 when the offset is not an allocated
// block; granted_address_o is 0 on failure. The node tree lives in a RAM of
// 2^(L+1) two-bit entries (L = tree depth, 8 by default) with one write and
// one registered read port, and that port sets the timing. After reset the
// block clears the RAM with busy high. An allocate searches the nodes in
// address order and then splits level by level down to the wanted size; a
// free descends level by level, looks up the block, then merges with free
// buddies one level at a time before it answers. busy drops in the cycle
// done_o rises, so the next transaction may start while a result is shown.
module buddy_block_allocator_core #(
  parameter int TOTAL_BYTES     = 4096,
  parameter int MIN_BLOCK_BYTES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cmd_i,
  input  logic [3:0]  size_order_i,
  input  logic [11:0] block_address_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [11:0] granted_address_o
);

  localparam int LEAF_RAW = TOTAL_BYTES / MIN_BLOCK_BYTES;
  localparam int LEAF_CNT = (LEAF_RAW > 0) ? LEAF_RAW : 1;
  localparam int LV       = bba_pkg::tree_levels(LEAF_CNT);
  localparam int AW       = $clog2(TOTAL_BYTES + 1);
  // Node start offsets can exceed 12 bits on larger regions; compare wide.
  localparam int CW       = (AW > bba_pkg::ADDR_W) ? AW : bba_pkg::ADDR_W;

  bba_pkg::dp_cmd_t  dp_cmd;
  bba_pkg::dp_stat_t dp_stat;

  bba_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .cmd_i (cmd_i),
    .stat_i(dp_stat),
    .cmd_o (dp_cmd),
    .busy  (busy)
  );

  bba_datapath #(
    .LV       (LV),
    .MIN_BYTES(MIN_BLOCK_BYTES),
    .CW       (CW)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (dp_cmd),
    .stat_o           (dp_stat),
    .size_order_i     (size_order_i),
    .block_address_i  (block_address_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .granted_address_o(granted_address_o)
  );

  // A result always lands with the engine back in idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result shown while busy");

  // An accepted transaction always makes the engine busy or answers at
  // once (oversized order).
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o)) else $error("accept lost");

  // Failures report a zero offset.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != bba_pkg::RSP_OK) |-> (granted_address_o == '0))
    else $error("nonzero offset on failure");

  // Only the three defined status codes appear.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == bba_pkg::RSP_OK || status_o == bba_pkg::RSP_NOFIT ||
                status_o == bba_pkg::RSP_BADADDR)) else $error("bad status");

endmodule

// File: sim/tb.sv
// Self-checking testbench for buddy_block_allocator_core: drives allocate and
// free transactions, predicts each response from a model of the node tree.
// Depends on bba_pkg and the allocator RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEVELS = 8;
  localparam int NODES  = (2 << LEVELS) - 1;
  localparam int WDOG_LIMIT = 200000;

  typedef struct packed {
    logic        cmd;
    logic [3:0]  order;
    logic [11:0] addr;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] addr;
  } rsp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        cmd_i = 1'b0;
  logic [3:0]  size_order_i = '0;
  logic [11:0] block_address_i = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic [11:0] granted_address_o;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  logic [1:0] tree_st[NODES];
  logic [11:0] live_blocks[$];
  int  idle_pct = 0;
  int  quiet_cycles = 0;
  bit  failed = 1'b0;
  bit  stim_done = 1'b0;

  buddy_block_allocator_core i_dut (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .size_order_i, .block_address_i,
    .done_o, .status_o, .granted_address_o
  );

  always #2 clk_i = ~clk_i;

  function automatic int depth_of(int idx);
    int d;
    int v;
    d = 0;
    v = idx + 1;
    while (v > 1) begin
      v = v >> 1;
      d++;
    end
    return d;
  endfunction

  function automatic int start_of(int idx);
    int d;
    d = depth_of(idx);
    return (idx + 1 - (1 << d)) * (16 << (LEVELS - d));
  endfunction

  // Advance the tree by one transaction and return the response it gives.
  function automatic rsp_t predict_alloc_free(req_t r);
    rsp_t rs;
    int want;
    int best;
    int best_start;
    int nd;
    int buddy;
    bit found;
    rs = '{status: bba_pkg::RSP_NOFIT, addr: '0};
    found = 1'b0;
    best = 0;
    best_start = 0;
    if (r.cmd == bba_pkg::CMD_ALLOC) begin
      if (r.order > LEVELS) return rs;
      want = LEVELS - r.order;
      for (int i = 0; i < NODES; i++) begin
        if (tree_st[i] == bba_pkg::NS_FREE && depth_of(i) <= want &&
            (!found || start_of(i) < best_start)) begin
          found = 1'b1;
          best = i;
          best_start = start_of(i);
        end
      end
      if (!found) return rs;
      while (depth_of(best) < want) begin
        tree_st[best] = bba_pkg::NS_SPLIT;
        tree_st[2*best+1] = bba_pkg::NS_FREE;
        tree_st[2*best+2] = bba_pkg::NS_FREE;
        best = 2*best + 1;
      end
      tree_st[best] = bba_pkg::NS_ALLOC;
      rs = '{status: bba_pkg::RSP_OK, addr: best_start[11:0]};
      live_blocks.push_back(best_start[11:0]);
    end else begin
      rs.status = bba_pkg::RSP_BADADDR;
      nd = 0;
      for (int i = 0; i < NODES; i++) begin
        if (!found && tree_st[i] == bba_pkg::NS_ALLOC && start_of(i) == r.addr) begin
          nd = i;
          found = 1'b1;
        end
      end
      if (!found) return rs;
      tree_st[nd] = bba_pkg::NS_FREE;
      while (nd > 0) begin
        buddy = nd[0] ? nd + 1 : nd - 1;
        if (tree_st[buddy] != bba_pkg::NS_FREE) break;
        tree_st[nd] = bba_pkg::NS_UNUSED;
        tree_st[buddy] = bba_pkg::NS_UNUSED;
        nd = (nd - 1) >> 1;
        tree_st[nd] = bba_pkg::NS_FREE;
      end
      rs = '{status: bba_pkg::RSP_OK, addr: r.addr};
    end
    return rs;
  endfunction

  // Driver: hold start while a transaction waits, drop it for idle gaps.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        expected_rsps.push_back(predict_alloc_free(pending_reqs.pop_front()));
      end
      if ((!start || !busy) && pending_reqs.size() > 0 &&
          $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        cmd_i <= pending_reqs[0].cmd;
        size_order_i <= pending_reqs[0].order;
        block_address_i <= pending_reqs[0].addr;
      end else if (!start || !busy) begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check each strobed response against the oldest expectation.
  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    quiet_cycles <= (done_o || (start && !busy)) ? 0 : quiet_cycles + 1;
    if (rst_ni && done_o) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected response status=%0d addr=%0d",
                 $time, status_o, granted_address_o);
        failed = 1'b1;
      end else begin
        exp_rsp = expected_rsps.pop_front();
        if (status_o !== exp_rsp.status || granted_address_o !== exp_rsp.addr) begin
          $display("%0t: mismatch expected status=%0d addr=%0d, got status=%0d addr=%0d",
                   $time, exp_rsp.status, exp_rsp.addr, status_o, granted_address_o);
          failed = 1'b1;
        end
      end
    end
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic push_req(logic c, logic [3:0] o, logic [11:0] a);
    pending_reqs.push_back('{cmd: c, order: o, addr: a});
  endtask

  // Queue a random transaction; mostly allocations and frees of live blocks, some noise.
  task automatic push_random();
    int k;
    int sel;
    sel = $urandom_range(99);
    if (sel < 45) begin
      push_req(bba_pkg::CMD_ALLOC,
               4'(($urandom_range(9) < 8) ? $urandom_range(4) : $urandom_range(15)),
               '0);
    end else if (sel < 85 && live_blocks.size() > 0) begin
      k = $urandom_range(live_blocks.size() - 1);
      push_req(bba_pkg::CMD_FREE, 4'($urandom), live_blocks[k]);
      live_blocks.delete(k);
    end else begin
      push_req(bba_pkg::CMD_FREE, 4'($urandom), 12'($urandom));
    end
  endtask

  initial begin
    for (int i = 0; i < NODES; i++) tree_st[i] = bba_pkg::NS_UNUSED;
    tree_st[0] = bba_pkg::NS_FREE;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed: whole region, too large, no fit, bad offsets, double free.
    push_req(bba_pkg::CMD_ALLOC, 4'd8, 12'hFFF);
    push_req(bba_pkg::CMD_ALLOC, 4'd0, '0);
    push_req(bba_pkg::CMD_FREE, 4'hF, 12'd0);
    push_req(bba_pkg::CMD_FREE, 4'd0, 12'd0);
    push_req(bba_pkg::CMD_ALLOC, 4'd9, '0);
    push_req(bba_pkg::CMD_ALLOC, 4'd15, '0);
    push_req(bba_pkg::CMD_ALLOC, 4'd0, '0);
    push_req(bba_pkg::CMD_ALLOC, 4'd3, '0);
    push_req(bba_pkg::CMD_ALLOC, 4'd7, '0);
    push_req(bba_pkg::CMD_FREE, 4'd0, 12'd8);
    push_req(bba_pkg::CMD_FREE, 4'd0, 12'd4095);
    push_req(bba_pkg::CMD_FREE, 4'd0, 12'd2048);
    push_req(bba_pkg::CMD_FREE, 4'd0, 12'd128);
    push_req(bba_pkg::CMD_FREE, 4'd0, 12'd0);
    push_req(bba_pkg::CMD_FREE, 4'd0, 12'd2048);
    for (int i = 0; i < 4; i++) push_req(bba_pkg::CMD_ALLOC, 4'd6, '0);
    push_req(bba_pkg::CMD_ALLOC, 4'd0, '0);
    for (int i = 0; i < 4; i++) push_req(bba_pkg::CMD_FREE, 4'd0, 12'(i * 1024));
    live_blocks.delete();
    // Random phases of sender idling.
    for (int ph = 0; ph < 4; ph++) begin
      wait (pending_reqs.size() == 0);
      idle_pct = (ph == 1) ? 48 : (ph == 3) ? 9 : 0;
      repeat (385) push_random();
    end
    wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
    repeat (200) @(posedge clk_i);
    if (!failed && expected_rsps.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
